// ===== rtl/core/sscp_pkg.sv =====
// shared types, constants and helpers for the sight line crossing slope clip block
package sscp_pkg;

  localparam logic signed [31:0] FRAC_MIN   = 32'sd4;
  localparam logic signed [31:0] FRAC_LIMIT = 32'sh0001_0001;
  localparam logic signed [31:0] SAT_POS    = 32'sh7fff_ffff;
  localparam logic signed [31:0] SAT_NEG    = 32'sh8000_0000;
  localparam int unsigned        DIV_STEPS  = 32;
  localparam int unsigned        QDEPTH     = 2;
  localparam logic               OP_START   = 1'b0;

  typedef struct packed {
    logic               op;
    logic signed [31:0] pos_ax;
    logic signed [31:0] pos_ay;
    logic signed [31:0] pos_bx;
    logic signed [31:0] pos_by;
    logic signed [31:0] height_a;
    logic signed [31:0] height_b;
    logic signed [31:0] height_c;
    logic signed [31:0] height_d;
    logic               has_back;
  } item_t;

  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [32:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

  function automatic logic signed [31:0] mul17(logic signed [16:0] a, logic signed [16:0] b);
    logic signed [33:0] p;
    p = a * b;
    return signed'(p[31:0]);
  endfunction

endpackage

// ===== rtl/core/sight_line_crossing_slope_clip.sv =====
// top level of the sight line crossing slope clip block
// channel  | direction | handshake          | payload
// in_      | input     | in_valid/in_stall   | op, positions, heights, has_back
// out_     | output    | out_valid/out_stall | blocked, crossed, top_now, bottom_now
// a start transaction and a line that misses the trace do not use the divider;
// a crossing line may use the shared 32-step divider once for its fraction and
// once more for each slope that it clips
// synchronous reset clears the trace state, the two-entry queue and the output register
// input stalls only when the queue is full; the back end waits while a result is stalled
module sight_line_crossing_slope_clip (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_op,
  input  logic signed [31:0] in_pos_ax,
  input  logic signed [31:0] in_pos_ay,
  input  logic signed [31:0] in_pos_bx,
  input  logic signed [31:0] in_pos_by,
  input  logic signed [31:0] in_height_a,
  input  logic signed [31:0] in_height_b,
  input  logic signed [31:0] in_height_c,
  input  logic signed [31:0] in_height_d,
  input  logic               in_has_back,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_blocked,
  output logic               out_crossed,
  output logic signed [31:0] out_top_now,
  output logic signed [31:0] out_bottom_now
);

  sscp_pkg::item_t    in_item, q_item;
  logic               q_valid, q_pop;
  sscp_pkg::div_req_t div_req;
  sscp_pkg::div_rsp_t div_rsp;

  always_comb begin
    in_item.op       = in_op;
    in_item.pos_ax   = in_pos_ax;
    in_item.pos_ay   = in_pos_ay;
    in_item.pos_bx   = in_pos_bx;
    in_item.pos_by   = in_pos_by;
    in_item.height_a = in_height_a;
    in_item.height_b = in_height_b;
    in_item.height_c = in_height_c;
    in_item.height_d = in_height_d;
    in_item.has_back = in_has_back;
  end

  sscp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  sscp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  sscp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .div_req        (div_req),
    .div_rsp        (div_rsp),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_blocked    (out_blocked),
    .out_crossed    (out_crossed),
    .out_top_now    (out_top_now),
    .out_bottom_now (out_bottom_now)
  );

endmodule

// ===== rtl/core/sscp_front.sv =====
// front end: accepts transactions and queues them for the back end
module sscp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sscp_pkg::item_t    in_item,
  output logic               q_valid,
  output sscp_pkg::item_t    q_item,
  input  logic               q_pop
);

  sscp_pkg::item_t mem_r [sscp_pkg::QDEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign in_stall = (cnt_r == 2'(sscp_pkg::QDEPTH));
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule

// ===== rtl/core/sscp_div.sv =====
// shared restoring divider, one quotient bit a cycle
module sscp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  sscp_pkg::div_req_t  req,
  output sscp_pkg::div_rsp_t  rsp
);

  logic [32:0] rem_r, rem_nxt;
  logic [32:0] dvs_r, dvs_nxt;
  logic [31:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;
  logic        ge;

  assign trial = {rem_r, q_r[31]};
  assign ge    = (trial >= {1'b0, dvs_r});

  always_comb begin
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt = {17'd0, req.dividend[47:32]};
      dvs_nxt = req.divisor;
      q_nxt   = req.dividend[31:0];
      cnt_nxt = 6'(sscp_pkg::DIV_STEPS);
    end else if (cnt_r != 6'd0) begin
      rem_nxt  = ge ? 33'(trial - {1'b0, dvs_r}) : trial[32:0];
      q_nxt    = {q_r[30:0], ge};
      cnt_nxt  = cnt_r - 6'd1;
      done_nxt = (cnt_r == 6'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 6'd0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = q_r;

endmodule

// ===== rtl/core/sscp_back.sv =====
// back end: trace state, crossing test, fraction and slope clipping sequencer
module sscp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  sscp_pkg::item_t     q_item,
  output logic                q_pop,
  output sscp_pkg::div_req_t  div_req,
  input  sscp_pkg::div_rsp_t  div_rsp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_blocked,
  output logic                out_crossed,
  output logic signed [31:0]  out_top_now,
  output logic signed [31:0]  out_bottom_now
);

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_SIDE2 = 14'b00000000000010,
    S_SIDE1 = 14'b00000000000100,
    S_D1    = 14'b00000000001000,
    S_D2    = 14'b00000000010000,
    S_DIVF  = 14'b00000000100000,
    S_WF    = 14'b00000001000000,
    S_CHK   = 14'b00000010000000,
    S_CB    = 14'b00000100000000,
    S_WB    = 14'b00001000000000,
    S_CT    = 14'b00010000000000,
    S_WT    = 14'b00100000000000,
    S_FIN   = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic signed [15:0] sx_r, sy_r, ex_r, ey_r;
  logic signed [31:0] eye_r, top_r, bot_r;
  logic               blk_r;
  logic signed [15:0] sx_nxt, sy_nxt, ex_nxt, ey_nxt;
  logic signed [31:0] eye_nxt, top_nxt, bot_nxt;
  logic               blk_nxt;

  sscp_pkg::item_t    cur_r, cur_nxt;
  logic signed [16:0] tx_r, ty_r, dx1_r, dy1_r, dx2_r, dy2_r, nx_r, ny_r, ux_r, uy_r;
  logic signed [16:0] tx_nxt, ty_nxt, dx1_nxt, dy1_nxt, dx2_nxt, dy2_nxt;
  logic signed [16:0] nx_nxt, ny_nxt, ux_nxt, uy_nxt;
  logic               side2_r, side2_nxt;
  logic signed [31:0] d1_r, d1_nxt, d2_r, d2_nxt, frac_r, frac_nxt;
  logic signed [31:0] otop_r, otop_nxt, obot_r, obot_nxt;
  logic               neg_r, neg_nxt, need_t_r, need_t_nxt, crossed_r, crossed_nxt;

  logic               ov_r, ov_nxt, ob_r, ob_nxt, oc_r, oc_nxt;
  logic signed [31:0] ot_r, ot_nxt, obo_r, obo_nxt;

  logic               out_free;
  logic signed [31:0] eye_c, bsum, nclip, qs, slope;
  logic signed [15:0] p1x, p1y, p2x, p2y;
  logic        [32:0] ma, mb;
  logic        [31:0] mn;
  logic signed [31:0] ff, fc, bf, bc, mint, maxb;
  logic               side1;

  assign out_free = !ov_r || !out_stall;
  assign p1x = cur_r.pos_ax[31:16];
  assign p1y = cur_r.pos_ay[31:16];
  assign p2x = cur_r.pos_bx[31:16];
  assign p2y = cur_r.pos_by[31:16];
  assign ff  = cur_r.height_a;
  assign fc  = cur_r.height_b;
  assign bf  = cur_r.height_c;
  assign bc  = cur_r.height_d;
  assign mint = (fc < bc) ? fc : bc;
  assign maxb = (ff > bf) ? ff : bf;
  assign eye_c = (q_item.height_a + q_item.height_b) - (q_item.height_b >>> 2);
  assign bsum  = d1_r + d2_r;
  assign ma    = d1_r[31] ? 33'(-{d1_r[31], d1_r}) : {1'b0, d1_r};
  assign mb    = bsum[31] ? 33'(-{bsum[31], bsum}) : {1'b0, bsum};
  assign nclip = ((state_r == S_CB ? obot_r : otop_r) - eye_r) <<< 6;
  assign mn    = nclip[31] ? 32'(-nclip) : 32'(nclip);
  assign qs    = neg_r ? 32'(-div_rsp.quotient) : 32'(div_rsp.quotient);
  assign slope = qs <<< 8;
  assign side1 = sscp_pkg::mul17(ty_r, dx1_r) < sscp_pkg::mul17(dy1_r, tx_r);

  always_comb begin
    state_nxt = state_r;
    sx_nxt = sx_r; sy_nxt = sy_r; ex_nxt = ex_r; ey_nxt = ey_r;
    eye_nxt = eye_r; top_nxt = top_r; bot_nxt = bot_r; blk_nxt = blk_r;
    cur_nxt = cur_r;
    tx_nxt = tx_r; ty_nxt = ty_r; dx1_nxt = dx1_r; dy1_nxt = dy1_r;
    dx2_nxt = dx2_r; dy2_nxt = dy2_r; nx_nxt = nx_r; ny_nxt = ny_r;
    ux_nxt = ux_r; uy_nxt = uy_r;
    side2_nxt = side2_r; d1_nxt = d1_r; d2_nxt = d2_r; frac_nxt = frac_r;
    otop_nxt = otop_r; obot_nxt = obot_r; neg_nxt = neg_r;
    need_t_nxt = need_t_r; crossed_nxt = crossed_r;
    ov_nxt = ov_r && out_stall;
    ob_nxt = ob_r; oc_nxt = oc_r; ot_nxt = ot_r; obo_nxt = obo_r;
    q_pop = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = 48'd0;
    div_req.divisor  = 33'd0;
    unique case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop       = 1'b1;
          cur_nxt     = q_item;
          crossed_nxt = 1'b0;
          if (q_item.op == sscp_pkg::OP_START) begin
            sx_nxt  = {q_item.pos_ax[31:17], 1'b1};
            sy_nxt  = {q_item.pos_ay[31:17], 1'b1};
            ex_nxt  = {q_item.pos_bx[31:17], 1'b1};
            ey_nxt  = {q_item.pos_by[31:17], 1'b1};
            eye_nxt = eye_c;
            top_nxt = (q_item.height_c + q_item.height_d) - eye_c;
            bot_nxt = q_item.height_c - eye_c;
            blk_nxt = 1'b0;
            state_nxt = S_OUT;
          end else if (blk_r) begin
            state_nxt = S_OUT;
          end else begin
            tx_nxt  = 17'(ex_r) - 17'(sx_r);
            ty_nxt  = 17'(ey_r) - 17'(sy_r);
            dx1_nxt = 17'(signed'(q_item.pos_ax[31:16])) - 17'(sx_r);
            dy1_nxt = 17'(signed'(q_item.pos_ay[31:16])) - 17'(sy_r);
            dx2_nxt = 17'(signed'(q_item.pos_bx[31:16])) - 17'(sx_r);
            dy2_nxt = 17'(signed'(q_item.pos_by[31:16])) - 17'(sy_r);
            nx_nxt  = 17'(signed'(q_item.pos_ay[31:16])) - 17'(signed'(q_item.pos_by[31:16]));
            ny_nxt  = 17'(signed'(q_item.pos_bx[31:16])) - 17'(signed'(q_item.pos_ax[31:16]));
            ux_nxt  = 17'(ex_r) - 17'(signed'(q_item.pos_ax[31:16]));
            uy_nxt  = 17'(ey_r) - 17'(signed'(q_item.pos_ay[31:16]));
            state_nxt = S_SIDE2;
          end
        end
      end
      S_SIDE2: begin
        side2_nxt = sscp_pkg::mul17(ty_r, dx2_r) < sscp_pkg::mul17(dy2_r, tx_r);
        state_nxt = S_SIDE1;
      end
      S_SIDE1: begin
        state_nxt = (side1 != side2_r) ? S_D1 : S_OUT;
      end
      S_D1: begin
        d1_nxt = sscp_pkg::mul17(nx_r, dx1_r) + sscp_pkg::mul17(ny_r, dy1_r);
        state_nxt = S_D2;
      end
      S_D2: begin
        d2_nxt = sscp_pkg::mul17(nx_r, ux_r) + sscp_pkg::mul17(ny_r, uy_r);
        state_nxt = S_DIVF;
      end
      S_DIVF: begin
        neg_nxt = d1_r[31] ^ bsum[31];
        if ((ma >> 14) >= mb) begin
          frac_nxt  = (d1_r[31] ^ bsum[31]) ? sscp_pkg::SAT_NEG : sscp_pkg::SAT_POS;
          state_nxt = S_CHK;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {ma[31:0], 16'd0};
          div_req.divisor  = mb;
          state_nxt = S_WF;
        end
      end
      S_WF: begin
        if (div_rsp.done) begin
          frac_nxt  = qs;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        otop_nxt = mint;
        obot_nxt = maxb;
        need_t_nxt = (fc != bc);
        if (frac_r < sscp_pkg::FRAC_MIN || frac_r >= sscp_pkg::FRAC_LIMIT) begin
          state_nxt = S_OUT;
        end else begin
          crossed_nxt = 1'b1;
          if (!cur_r.has_back) begin
            blk_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else if (ff == bf && fc == bc) begin
            state_nxt = S_OUT;
          end else if (maxb >= mint) begin
            blk_nxt   = 1'b1;
            state_nxt = S_OUT;
          end else begin
            state_nxt = (ff != bf) ? S_CB : S_CT;
          end
        end
      end
      S_CB, S_CT: begin
        neg_nxt          = nclip[31];
        div_req.start    = 1'b1;
        div_req.dividend = {16'd0, mn};
        div_req.divisor  = {18'd0, frac_r[16:2]};
        state_nxt = (state_r == S_CB) ? S_WB : S_WT;
      end
      S_WB: begin
        if (div_rsp.done) begin
          if (slope > bot_r) begin
            bot_nxt = slope;
          end
          state_nxt = need_t_r ? S_CT : S_FIN;
        end
      end
      S_WT: begin
        if (div_rsp.done) begin
          if (slope < top_r) begin
            top_nxt = slope;
          end
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (top_r <= bot_r) begin
          blk_nxt = 1'b1;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ov_nxt  = 1'b1;
        ob_nxt  = blk_r;
        oc_nxt  = crossed_r;
        ot_nxt  = top_r;
        obo_nxt = bot_r;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sx_r <= '0; sy_r <= '0; ex_r <= '0; ey_r <= '0;
      eye_r <= '0; top_r <= '0; bot_r <= '0; blk_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sx_r <= sx_nxt; sy_r <= sy_nxt; ex_r <= ex_nxt; ey_r <= ey_nxt;
      eye_r <= eye_nxt; top_r <= top_nxt; bot_r <= bot_nxt; blk_r <= blk_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    tx_r <= tx_nxt; ty_r <= ty_nxt; dx1_r <= dx1_nxt; dy1_r <= dy1_nxt;
    dx2_r <= dx2_nxt; dy2_r <= dy2_nxt; nx_r <= nx_nxt; ny_r <= ny_nxt;
    ux_r <= ux_nxt; uy_r <= uy_nxt;
    side2_r <= side2_nxt; d1_r <= d1_nxt; d2_r <= d2_nxt; frac_r <= frac_nxt;
    otop_r <= otop_nxt; obot_r <= obot_nxt; neg_r <= neg_nxt;
    need_t_r <= need_t_nxt; crossed_r <= crossed_nxt;
    ob_r <= ob_nxt; oc_r <= oc_nxt; ot_r <= ot_nxt; obo_r <= obo_nxt;
  end

  assign out_valid      = ov_r;
  assign out_blocked    = ob_r;
  assign out_crossed    = oc_r;
  assign out_top_now    = ot_r;
  assign out_bottom_now = obo_r;

endmodule

// ===== rtl/core/sscp_checker.sv =====
// port checker for the sight line crossing slope clip block, with its bind
module sscp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_blocked,
  input logic               out_crossed,
  input logic signed [31:0] out_top_now,
  input logic signed [31:0] out_bottom_now
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_blocked) && $stable(out_crossed)
      && $stable(out_top_now) && $stable(out_bottom_now))
    else $error("stalled result changed");

  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // reset empties the queue
  a_rst_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind sight_line_crossing_slope_clip sscp_checker u_sscp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_blocked    (out_blocked),
  .out_crossed    (out_crossed),
  .out_top_now    (out_top_now),
  .out_bottom_now (out_bottom_now)
);
